### hw/rtl/assert_macros.svh
// Assertion macros shared by the pixel blend RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   `ASSERT_PROP(label, clk, rst, ((ante) |-> (cons)))

`endif

### hw/rtl/pabfc_pkg.sv
// Shared types, constants and arithmetic helpers for the pixel blend/convert core
package pabfc_pkg;

   localparam int COLOR_W = 24;
   localparam int CHAN_W  = 8;
   localparam int WORD_W  = 32;
   localparam int CSR_W   = 3;

   localparam logic [CSR_W-1:0] CSR_BACKGROUND = 3'd0;
   localparam logic [CSR_W-1:0] CSR_MODE       = 3'd1;
   localparam logic [CSR_W-1:0] CSR_RED_MASK   = 3'd2;
   localparam logic [CSR_W-1:0] CSR_GREEN_MASK = 3'd3;
   localparam logic [CSR_W-1:0] CSR_BLUE_MASK  = 3'd4;

   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 24'h081018;
   localparam logic [WORD_W-1:0]  RED_MASK_RESET   = 32'h00FF0000;
   localparam logic [WORD_W-1:0]  GREEN_MASK_RESET = 32'h0000FF00;
   localparam logic [WORD_W-1:0]  BLUE_MASK_RESET  = 32'h000000FF;

   typedef struct packed {
      logic       zero;
      logic       full;
      logic [4:0] pos;
      logic [4:0] run;
   } mask_info_type;

   // exact x/255 for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] y;
      y = 17'(x) + 17'(x[15:8]) + 17'd1;
      return y[15:8];
   endfunction

   function automatic logic [7:0] mix_channel(input logic [7:0] f, input logic [7:0] b,
                                              input logic [7:0] a);
      logic [15:0] pf;
      logic [15:0] pb;
      logic [15:0] sum;
      pf  = 16'(f) * 16'(a);
      pb  = 16'(b) * 16'(8'd255 - a);
      sum = pf + pb + 16'd127;
      return div255(sum);
   endfunction

   // lowest run of ones: position and width
   function automatic mask_info_type mask_decode(input logic [WORD_W-1:0] mask);
      mask_info_type info;
      logic [WORD_W-1:0] low;
      logic [WORD_W:0]   above;
      logic [5:0]        top_idx;
      low        = mask & (~mask + 32'd1);
      above      = ({1'b0, mask} + {1'b0, low}) & ~{1'b0, mask};
      info.zero  = (mask == '0);
      info.full  = (mask == '1);
      info.pos   = '0;
      top_idx    = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (low[i]) info.pos = info.pos | 5'(i);
      end
      for (int i = 0; i <= WORD_W; i++) begin
         if (above[i]) top_idx = top_idx | 6'(i);
      end
      info.run = 5'(top_idx - {1'b0, info.pos});
      return info;
   endfunction

endpackage

### hw/rtl/pabfc_blend.sv
// Per-channel alpha blend of foreground over background, registered
module pabfc_blend (
   input  logic                            clock,
   input  logic [pabfc_pkg::COLOR_W-1:0]   fg_color,
   input  logic [pabfc_pkg::CHAN_W-1:0]    coverage,
   input  logic [pabfc_pkg::COLOR_W-1:0]   bg_color,
   output logic [pabfc_pkg::COLOR_W-1:0]   mix_color
);
   import pabfc_pkg::*;

   logic [COLOR_W-1:0] mix_in;
   logic [COLOR_W-1:0] mix_ff;

   always_comb begin
      mix_in = '0;
      for (int c = 0; c < 3; c++) begin
         mix_in[c*CHAN_W +: CHAN_W] = mix_channel(fg_color[c*CHAN_W +: CHAN_W],
                                                  bg_color[c*CHAN_W +: CHAN_W], coverage);
      end
   end

   always_ff @(posedge clock) begin
      mix_ff <= mix_in;
   end

   assign mix_color = mix_ff;

endmodule

### hw/rtl/pabfc_pack.sv
// Rescales one blended channel to its mask run and places it in the pixel word
module pabfc_pack (
   input  logic                           clock,
   input  logic [pabfc_pkg::CHAN_W-1:0]   mix,
   input  logic [pabfc_pkg::WORD_W-1:0]   mask,
   input  pabfc_pkg::mask_info_type       info,
   output logic [pabfc_pkg::WORD_W-1:0]   pack_word
);
   import pabfc_pkg::*;

   logic [14:0]       w_in;
   logic [14:0]       w_ff;
   logic [6:0]        small_in;
   logic [6:0]        small_ff;
   logic [15:0]       rem;
   logic [7:0]        quot;
   logic [1:0]        k;
   logic [WORD_W-1:0] scaled;

   // v*(2^run-1)/255 = (v<<run%8)*0x..0101 + ((v<<run%8) - v + 127)/255
   always_comb begin
      w_in     = {7'b0, mix} << info.run[2:0];
      rem      = 16'(w_in) - 16'(mix) + 16'd127;
      quot     = div255(rem);
      small_in = quot[6:0];
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      small_ff <= small_in;
   end

   always_comb begin
      k      = info.run[4:3];
      scaled = {25'b0, small_ff}
             + ((k != 2'd0) ? {17'b0, w_ff} : '0)
             + (k[1] ? {9'b0, w_ff, 8'b0} : '0)
             + ((k == 2'd3) ? {1'b0, w_ff, 16'b0} : '0);
      if (info.zero) begin
         pack_word = '0;
      end else if (info.full) begin
         pack_word = mask;
      end else begin
         pack_word = (scaled << info.pos) & mask;
      end
   end

endmodule

### hw/rtl/pixel_alpha_blend_format_convert_core.sv
// Top level: glyph pixel alpha blend and framebuffer format conversion
//
// Usage:
//   Input: drive req_fg_color (RGB888) and req_coverage (8-bit alpha) with
//   start high; a transfer happens at each clock edge where start is high
//   and busy is low. busy is high only during reset, so a new pixel can be
//   taken in every cycle.
//   Output: rsp_strobe is high for one cycle with rsp_pixel_word; the
//   receiver cannot stall, so no backpressure exists.
//   Path: an accepted pixel passes the input register, blend register,
//   rescale register and result register. Throughput: one pixel per clock.
//   Registers via csr_we/csr_addr/csr_wdata: 0 background, 1 bitmask mode,
//   2..4 red/green/blue masks. Write them only while no pixel is in flight.
//   Mask decode happens at write time.
//   Reset: synchronous, clears the pipeline valid bits and restores register defaults.
`include "assert_macros.svh"

module pixel_alpha_blend_format_convert_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [pabfc_pkg::COLOR_W-1:0]   req_fg_color,
   input  logic [pabfc_pkg::CHAN_W-1:0]    req_coverage,
   output logic                            rsp_strobe,
   output logic [pabfc_pkg::WORD_W-1:0]    rsp_pixel_word,
   input  logic                            csr_we,
   input  logic [pabfc_pkg::CSR_W-1:0]     csr_addr,
   input  logic [pabfc_pkg::WORD_W-1:0]    csr_wdata
);
   import pabfc_pkg::*;

   logic                accept;
   logic [COLOR_W-1:0]  bg_ff;
   logic                use_bitmask_ff;
   logic [WORD_W-1:0]   red_mask_ff;
   logic [WORD_W-1:0]   green_mask_ff;
   logic [WORD_W-1:0]   blue_mask_ff;
   mask_info_type       red_info_ff;
   mask_info_type       green_info_ff;
   mask_info_type       blue_info_ff;
   mask_info_type       wr_info;

   logic [COLOR_W-1:0]  fg_ff;
   logic [CHAN_W-1:0]   cov_ff;
   logic                s0_valid_ff;
   logic                s1_valid_ff;
   logic                s2_valid_ff;
   logic [COLOR_W-1:0]  mix_color;
   logic [COLOR_W-1:0]  mix2_ff;
   logic [WORD_W-1:0]   red_word;
   logic [WORD_W-1:0]   green_word;
   logic [WORD_W-1:0]   blue_word;
   logic [WORD_W-1:0]   rsp_word_in;
   logic [WORD_W-1:0]   rsp_word_ff;
   logic                rsp_strobe_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   assign wr_info = mask_decode(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff          <= BACKGROUND_RESET;
         use_bitmask_ff <= 1'b0;
         red_mask_ff    <= RED_MASK_RESET;
         green_mask_ff  <= GREEN_MASK_RESET;
         blue_mask_ff   <= BLUE_MASK_RESET;
         red_info_ff    <= mask_decode(RED_MASK_RESET);
         green_info_ff  <= mask_decode(GREEN_MASK_RESET);
         blue_info_ff   <= mask_decode(BLUE_MASK_RESET);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BACKGROUND: bg_ff <= csr_wdata[COLOR_W-1:0];
            CSR_MODE:       use_bitmask_ff <= csr_wdata[0];
            CSR_RED_MASK: begin
               red_mask_ff <= csr_wdata;
               red_info_ff <= wr_info;
            end
            CSR_GREEN_MASK: begin
               green_mask_ff <= csr_wdata;
               green_info_ff <= wr_info;
            end
            CSR_BLUE_MASK: begin
               blue_mask_ff <= csr_wdata;
               blue_info_ff <= wr_info;
            end
            default: ;
         endcase
      end
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s0_valid_ff   <= accept;
         s1_valid_ff   <= s0_valid_ff;
         s2_valid_ff   <= s1_valid_ff;
         rsp_strobe_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fg_ff  <= req_fg_color;
         cov_ff <= req_coverage;
      end
      mix2_ff     <= mix_color;
      rsp_word_ff <= rsp_word_in;
   end

   pabfc_blend u_blend (
      .clock     (clock),
      .fg_color  (fg_ff),
      .coverage  (cov_ff),
      .bg_color  (bg_ff),
      .mix_color (mix_color)
   );

   pabfc_pack u_pack_red (
      .clock     (clock),
      .mix       (mix_color[23:16]),
      .mask      (red_mask_ff),
      .info      (red_info_ff),
      .pack_word (red_word)
   );

   pabfc_pack u_pack_green (
      .clock     (clock),
      .mix       (mix_color[15:8]),
      .mask      (green_mask_ff),
      .info      (green_info_ff),
      .pack_word (green_word)
   );

   pabfc_pack u_pack_blue (
      .clock     (clock),
      .mix       (mix_color[7:0]),
      .mask      (blue_mask_ff),
      .info      (blue_info_ff),
      .pack_word (blue_word)
   );

   always_comb begin
      if (use_bitmask_ff) begin
         rsp_word_in = red_word | green_word | blue_word;
      end else begin
         rsp_word_in = {8'h00, mix2_ff};
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_pixel_word = rsp_word_ff;

   `ASSERT_IMPLY(a_rsp_latency, clock, reset, rsp_strobe, $past(accept, 4))
   `ASSERT_IMPLY(a_direct_top_zero, clock, reset, rsp_strobe && !use_bitmask_ff,
                 rsp_pixel_word[31:24] == 8'h00)
   `ASSERT_IMPLY(a_zero_cov_bg, clock, reset,
                 rsp_strobe && !use_bitmask_ff && $past(req_coverage == 8'h00, 4),
                 rsp_pixel_word[23:0] == bg_ff)
   `ASSERT_IMPLY(a_full_cov_fg, clock, reset,
                 rsp_strobe && !use_bitmask_ff && $past(req_coverage == 8'hFF, 4),
                 rsp_pixel_word[23:0] == $past(req_fg_color, 4))

endmodule
